### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Types, character codes and helper functions of the track parser.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam int PAN_DIGITS  = 19;
	localparam int PAN_MAX_DEF = 19;
	localparam int PAN_CNT_W   = 5;
	localparam int LOW_DIGITS  = 16;
	localparam int FCNT_W      = 3;
	localparam int ECNT_W      = 3;
	localparam int EXP_CHARS   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [11:0] YEAR_BASE = 12'd2000;

	localparam logic [1:0] SRC_NONE   = 2'd0;
	localparam logic [1:0] SRC_TRACK1 = 2'd1;
	localparam logic [1:0] SRC_TRACK2 = 2'd2;

	localparam logic [1:0] SEG_FIRST  = 2'd1;
	localparam logic [1:0] SEG_SECOND = 2'd2;
	localparam logic [1:0] SEG_MAX    = 2'd3;

	// Field counts: the date field of track 1 is the third, of track 2 the second.
	localparam logic [FCNT_W-1:0] FCNT_PAN      = 3'd1;
	localparam logic [FCNT_W-1:0] FCNT_T1_DATE  = 3'd3;
	localparam logic [FCNT_W-1:0] FCNT_T2_DATE  = 3'd2;
	localparam logic [FCNT_W-1:0] FCNT_SAT      = 3'd4;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
		logic       is_semi;
		logic       is_caret;
		logic       is_equal;
		logic       is_digit;
	} msp_item_t;

	typedef struct packed {
		logic [FCNT_W-1:0]       field_count;
		logic [PAN_CNT_W-1:0]    pan_count;
		logic                    pan_overflow;
		logic [4*PAN_DIGITS-1:0] pan_bcd;
		logic [ECNT_W-1:0]       exp_count;
		logic [8*EXP_CHARS-1:0]  exp_chars;
	} msp_view_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Two ASCII digits to a value 0..99; any non-digit gives 0.
	function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		logic [6:0] tens;
		logic [6:0] ones;
		tens = {3'b000, hi[3:0]};
		ones = {3'b000, lo[3:0]};
		if (!is_digit(hi) || !is_digit(lo)) begin
			return 7'd0;
		end
		return (tens << 3) + (tens << 1) + ones;
	endfunction

endpackage

`default_nettype wire

### rtl/core/magstripe_track_parser.sv
// ----------------------------------------------------------------------------
// magstripe_track_parser
// Parses card track 1 / track 2 text and reports account number and expiry.
//
//   Channel  Dir  Handshake            Payload
//   input    in   in_valid, in_stall   char_code, last_char
//   result   out  out_valid, out_stall pan_digits_low/high, pan_length,
//                                      pan_overflow, source_track,
//                                      expiry_valid, expiry_year, expiry_month
//
// One character is taken every cycle while in_stall is low; the back end
// parses one queued item per cycle unless a held result stalls it, so the rate is set by its segment and field update.
// The result is loaded into the output register at the edge where the last
// character leaves the two-entry queue.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result holds the back end; the queue then fills and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module magstripe_track_parser #(
	parameter int PAN_MAX = msp_pkg::PAN_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic  [7:0] char_code,
	input  wire logic        last_char,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] pan_digits_low,
	output logic      [11:0] pan_digits_high,
	output logic       [4:0] pan_length,
	output logic             pan_overflow,
	output logic       [1:0] source_track,
	output logic             expiry_valid,
	output logic      [11:0] expiry_year,
	output logic       [6:0] expiry_month
);

	logic               queue_full;
	logic               push;
	msp_pkg::msp_item_t push_item;
	logic               pop;
	logic               pop_valid;
	msp_pkg::msp_item_t pop_item;

	msp_classify u_front (
		.char_code (char_code),
		.last_char (last_char),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.queue_full(queue_full),
		.push      (push),
		.push_item (push_item)
	);

	msp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (queue_full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_item (pop_item)
	);

	msp_assemble #(
		.PAN_MAX(PAN_MAX)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (pop_valid),
		.q_item         (pop_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pan_digits_low (pan_digits_low),
		.pan_digits_high(pan_digits_high),
		.pan_length     (pan_length),
		.pan_overflow   (pan_overflow),
		.source_track   (source_track),
		.expiry_valid   (expiry_valid),
		.expiry_year    (expiry_year),
		.expiry_month   (expiry_month)
	);

	`ASSERT_NEVER(a_len_limit, out_valid && (pan_length > 5'(PAN_MAX)), "account length over limit")
	`ASSERT_HOLDS(a_no_source, (out_valid && (source_track == msp_pkg::SRC_NONE)) |-> ((pan_length == 5'd0) && !expiry_valid && !pan_overflow), "result without source carries data")
	`ASSERT_HOLDS(a_no_expiry, (out_valid && !expiry_valid) |-> ((expiry_year == 12'd0) && (expiry_month == 7'd0)), "expiry fields set without expiry")
	`ASSERT_HOLDS(a_year_range, (out_valid && expiry_valid) |-> ((expiry_year >= msp_pkg::YEAR_BASE) && (expiry_year <= 12'd2099) && (expiry_month <= 7'd99)), "expiry out of range")

endmodule

`default_nettype wire

### rtl/core/msp_classify.sv
// ----------------------------------------------------------------------------
// msp_classify
// Front end: takes characters and tags separators and digits for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_classify (
	input  wire logic              [7:0] char_code,
	input  wire logic                    last_char,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    queue_full,
	output logic                         push,
	output msp_pkg::msp_item_t           push_item
);

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_item.char_code = char_code;
		push_item.last      = last_char;
		push_item.is_semi   = (char_code == msp_pkg::CH_SEMI);
		push_item.is_caret  = (char_code == msp_pkg::CH_CARET);
		push_item.is_equal  = (char_code == msp_pkg::CH_EQUAL);
		push_item.is_digit  = msp_pkg::is_digit(char_code);
	end

endmodule

`default_nettype wire

### rtl/core/msp_queue.sv
// ----------------------------------------------------------------------------
// msp_queue
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire msp_pkg::msp_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    pop_valid,
	output msp_pkg::msp_item_t      pop_item
);

	localparam int DEPTH = msp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	msp_pkg::msp_item_t slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### rtl/core/msp_field.sv
// ----------------------------------------------------------------------------
// msp_field
// Field splitter for one track: collects account digits and date characters.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_field #(
	parameter int PAN_MAX = msp_pkg::PAN_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              feed,
	input  wire logic                              clear_pre,
	input  wire logic                              clear_post,
	input  wire msp_pkg::msp_item_t                item,
	input  wire logic                              is_sep,
	input  wire logic [msp_pkg::FCNT_W-1:0]        date_fcount,
	output msp_pkg::msp_view_t                     view
);

	localparam int CNT_W  = msp_pkg::PAN_CNT_W;
	localparam int FC_W   = msp_pkg::FCNT_W;
	localparam int EC_W   = msp_pkg::ECNT_W;
	localparam int IDX_W  = (PAN_MAX > 1) ? $clog2(PAN_MAX) : 1;
	localparam int EIDX_W = $clog2(msp_pkg::EXP_CHARS);

	logic [FC_W-1:0]  fcount_q;
	logic             fopen_q;
	logic [CNT_W-1:0] pcount_q;
	logic             pover_q;
	logic [EC_W-1:0]  ecount_q;
	logic [3:0]       store_q [PAN_MAX];
	logic [7:0]       echars_q [msp_pkg::EXP_CHARS];

	logic [FC_W-1:0]  fcount_b, fcount_n;
	logic             fopen_b, fopen_n;
	logic [CNT_W-1:0] pcount_b, pcount_n;
	logic             pover_b, pover_n;
	logic [EC_W-1:0]  ecount_b, ecount_n;
	logic             pan_we;
	logic             exp_we;
	logic [IDX_W-1:0]  pan_idx;
	logic [EIDX_W-1:0] exp_idx;

	// A clear that comes with the item takes effect before the item is parsed.
	always_comb begin
		fcount_b = clear_pre ? '0 : fcount_q;
		fopen_b  = clear_pre ? 1'b0 : fopen_q;
		pcount_b = clear_pre ? '0 : pcount_q;
		pover_b  = clear_pre ? 1'b0 : pover_q;
		ecount_b = clear_pre ? '0 : ecount_q;

		fcount_n = fcount_b;
		fopen_n  = fopen_b;
		pcount_n = pcount_b;
		pover_n  = pover_b;
		ecount_n = ecount_b;
		pan_we   = 1'b0;
		exp_we   = 1'b0;

		if (feed) begin
			if (is_sep) begin
				fopen_n = 1'b0;
			end else begin
				if (!fopen_b) begin
					fopen_n = 1'b1;
					if (fcount_b < msp_pkg::FCNT_SAT) begin
						fcount_n = fcount_b + 1'b1;
					end
				end
				if (fcount_n == msp_pkg::FCNT_PAN) begin
					if (item.is_digit) begin
						if (pcount_b < CNT_W'(PAN_MAX)) begin
							pan_we   = 1'b1;
							pcount_n = pcount_b + 1'b1;
						end else begin
							pover_n = 1'b1;
						end
					end
				end else if (fcount_n == date_fcount) begin
					if (ecount_b < EC_W'(msp_pkg::EXP_CHARS)) begin
						exp_we   = 1'b1;
						ecount_n = ecount_b + 1'b1;
					end
				end
			end
		end
	end

	assign pan_idx = pcount_b[IDX_W-1:0];
	assign exp_idx = ecount_b[EIDX_W-1:0];

	// The view shows the state as it stands after this item.
	assign view.field_count  = fcount_n;
	assign view.pan_count    = pcount_n;
	assign view.pan_overflow = pover_n;
	assign view.exp_count    = ecount_n;

	for (genvar g = 0; g < msp_pkg::PAN_DIGITS; g++) begin : g_digit
		if (g < PAN_MAX) begin : g_kept
			assign view.pan_bcd[4*g +: 4] = (CNT_W'(g) < pcount_n)
				? ((pan_we && (pan_idx == IDX_W'(g))) ? item.char_code[3:0] : store_q[g])
				: 4'd0;
		end else begin : g_unused
			assign view.pan_bcd[4*g +: 4] = 4'd0;
		end
	end

	for (genvar e = 0; e < msp_pkg::EXP_CHARS; e++) begin : g_exp
		assign view.exp_chars[8*e +: 8] =
			(exp_we && (exp_idx == EIDX_W'(e))) ? item.char_code : echars_q[e];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
			fopen_q  <= 1'b0;
			pcount_q <= '0;
			pover_q  <= 1'b0;
			ecount_q <= '0;
		end else if (clear_post) begin
			fcount_q <= '0;
			fopen_q  <= 1'b0;
			pcount_q <= '0;
			pover_q  <= 1'b0;
			ecount_q <= '0;
		end else begin
			fcount_q <= fcount_n;
			fopen_q  <= fopen_n;
			pcount_q <= pcount_n;
			pover_q  <= pover_n;
			ecount_q <= ecount_n;
		end
	end

	// Entries past the counts never reach a result, so the stores need no reset.
	always_ff @(posedge clk) begin
		if (pan_we) begin
			store_q[pan_idx] <= item.char_code[3:0];
		end
		if (exp_we) begin
			echars_q[exp_idx] <= item.char_code;
		end
	end

endmodule

`default_nettype wire

### rtl/core/msp_assemble.sv
// ----------------------------------------------------------------------------
// msp_assemble
// Back end: tracks segments, drives both field splitters and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_assemble #(
	parameter int PAN_MAX = msp_pkg::PAN_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire msp_pkg::msp_item_t q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [63:0] pan_digits_low,
	output logic             [11:0] pan_digits_high,
	output logic              [4:0] pan_length,
	output logic                    pan_overflow,
	output logic              [1:0] source_track,
	output logic                    expiry_valid,
	output logic             [11:0] expiry_year,
	output logic              [6:0] expiry_month
);

	localparam int LOW_W = 4 * msp_pkg::LOW_DIGITS;
	localparam int BCD_W = 4 * msp_pkg::PAN_DIGITS;

	logic [1:0] seg_q, seg_n;
	logic       open_q, open_n;
	logic       caret_q, caret_n;
	logic       out_valid_q;
	logic       take;
	logic       finish;
	logic       clr_second;
	logic       feed_first;
	logic       feed_second;

	msp_pkg::msp_view_t view1;
	msp_pkg::msp_view_t view2;
	msp_pkg::msp_view_t sel;

	logic        t1_fields;
	logic        t1_valid;
	logic        t2_present;
	logic        t2_use;
	logic        have_pan;
	logic [63:0] r_low;
	logic [11:0] r_high;
	logic [4:0]  r_len;
	logic        r_ovf;
	logic [1:0]  r_src;
	logic        r_expv;
	logic [11:0] r_year;
	logic [6:0]  r_month;

	assign take   = q_valid && (!out_valid_q || !out_stall);
	assign pop    = take;
	assign finish = take && q_item.last;

	always_comb begin
		seg_n       = seg_q;
		open_n      = open_q;
		caret_n     = caret_q;
		clr_second  = 1'b0;
		feed_first  = 1'b0;
		feed_second = 1'b0;
		if (take) begin
			if (q_item.is_semi) begin
				open_n = 1'b0;
			end else begin
				if (!open_q) begin
					open_n = 1'b1;
					if (seg_q < msp_pkg::SEG_MAX) begin
						seg_n = seg_q + 1'b1;
					end
					// A second segment restarts the track 2 splitter.
					clr_second = (seg_n == msp_pkg::SEG_SECOND);
				end
				if (seg_n == msp_pkg::SEG_FIRST) begin
					caret_n     = caret_q || q_item.is_caret;
					feed_first  = 1'b1;
					feed_second = 1'b1;
				end else if (seg_n == msp_pkg::SEG_SECOND) begin
					feed_second = 1'b1;
				end
			end
		end
	end

	msp_field #(
		.PAN_MAX(PAN_MAX)
	) u_track1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed_first),
		.clear_pre  (1'b0),
		.clear_post (finish),
		.item       (q_item),
		.is_sep     (q_item.is_caret),
		.date_fcount(msp_pkg::FCNT_T1_DATE),
		.view       (view1)
	);

	msp_field #(
		.PAN_MAX(PAN_MAX)
	) u_track2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed_second),
		.clear_pre  (clr_second),
		.clear_post (finish),
		.item       (q_item),
		.is_sep     (q_item.is_equal),
		.date_fcount(msp_pkg::FCNT_T2_DATE),
		.view       (view2)
	);

	// Track 1 wins when it has a full date; otherwise track 2 may take over.
	always_comb begin
		t1_fields  = caret_n && (view1.field_count >= msp_pkg::FCNT_T1_DATE);
		t1_valid   = t1_fields && (view1.exp_count >= msp_pkg::ECNT_W'(msp_pkg::EXP_CHARS));
		t2_present = (seg_n >= msp_pkg::SEG_SECOND)
			|| ((seg_n == msp_pkg::SEG_FIRST) && !caret_n);
		t2_use     = !t1_valid && t2_present
			&& (view2.field_count >= msp_pkg::FCNT_T2_DATE);
		have_pan   = t1_fields || t2_use;
		sel        = t2_use ? view2 : view1;

		r_low   = '0;
		r_high  = '0;
		r_len   = '0;
		r_ovf   = 1'b0;
		r_src   = msp_pkg::SRC_NONE;
		r_expv  = 1'b0;
		r_year  = '0;
		r_month = '0;
		if (have_pan) begin
			r_low  = sel.pan_bcd[LOW_W-1:0];
			r_high = sel.pan_bcd[BCD_W-1:LOW_W];
			r_len  = sel.pan_count;
			r_ovf  = sel.pan_overflow;
			r_src  = t2_use ? msp_pkg::SRC_TRACK2 : msp_pkg::SRC_TRACK1;
			r_expv = (sel.exp_count >= msp_pkg::ECNT_W'(msp_pkg::EXP_CHARS));
			if (r_expv) begin
				r_year  = {5'b00000, msp_pkg::two_digits(sel.exp_chars[7:0],
					sel.exp_chars[15:8])} + msp_pkg::YEAR_BASE;
				r_month = msp_pkg::two_digits(sel.exp_chars[23:16], sel.exp_chars[31:24]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= '0;
			open_q      <= 1'b0;
			caret_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				seg_q   <= '0;
				open_q  <= 1'b0;
				caret_q <= 1'b0;
			end else begin
				seg_q   <= seg_n;
				open_q  <= open_n;
				caret_q <= caret_n;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			pan_digits_low  <= r_low;
			pan_digits_high <= r_high;
			pan_length      <= r_len;
			pan_overflow    <= r_ovf;
			source_track    <= r_src;
			expiry_valid    <= r_expv;
			expiry_year     <= r_year;
			expiry_month    <= r_month;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### verif/magstripe_track_parser_tb.sv
// ----------------------------------------------------------------------------
// magstripe_track_parser_tb
// Feeds card track texts one character at a time, predicts each account
// number and expiry result, and compares every result field by field.
// ----------------------------------------------------------------------------
module magstripe_track_parser_tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_START     = 600;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_CHARS   = 750;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} track_char_t;

	// One field splitter: counts fields, keeps first-field digits and date chars.
	typedef struct packed {
		logic [msp_pkg::FCNT_W-1:0]    nfields;
		logic                          in_field;
		logic [18:0][3:0]              pan;
		logic [msp_pkg::PAN_CNT_W-1:0] pan_cnt;
		logic                          pan_ovf;
		logic [3:0][7:0]               date;
		logic [msp_pkg::ECNT_W-1:0]    date_cnt;
	} field_split_t;

	typedef struct packed {
		logic [63:0] pan_lo;
		logic [11:0] pan_hi;
		logic [4:0]  pan_len;
		logic        pan_ovf;
		logic [1:0]  src;
		logic        exp_valid;
		logic [11:0] year;
		logic [6:0]  month;
	} track_result_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  char_code = 8'h00;
	logic        last_char = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] pan_digits_low;
	logic [11:0] pan_digits_high;
	logic [4:0]  pan_length;
	logic        pan_overflow;
	logic [1:0]  source_track;
	logic        expiry_valid;
	logic [11:0] expiry_year;
	logic [6:0]  expiry_month;

	track_char_t   pending_chars[$];
	track_result_t expected_results[$];
	logic [7:0]    track_text[$];
	int            errors = 0;
	int            idle_cycles = 0;

	// Parser state of the prediction.
	logic [1:0]    seg_count;
	logic          seg_open;
	logic          caret_found;
	field_split_t  track1_split;
	field_split_t  track2_split;

	magstripe_track_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_code      (char_code),
		.last_char      (last_char),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pan_digits_low (pan_digits_low),
		.pan_digits_high(pan_digits_high),
		.pan_length     (pan_length),
		.pan_overflow   (pan_overflow),
		.source_track   (source_track),
		.expiry_valid   (expiry_valid),
		.expiry_year    (expiry_year),
		.expiry_month   (expiry_month)
	);

	function automatic logic ascii_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic int yymm_value(logic [7:0] tens, logic [7:0] ones);
		if (!ascii_digit(tens) || !ascii_digit(ones)) begin
			return 0;
		end
		return (tens - 8'h30) * 10 + (ones - 8'h30);
	endfunction

	function automatic field_split_t split_step(field_split_t s, logic [7:0] c,
			logic [7:0] sep, logic [msp_pkg::FCNT_W-1:0] date_field);
		if (c == sep) begin
			s.in_field = 1'b0;
			return s;
		end
		if (!s.in_field) begin
			s.in_field = 1'b1;
			if (s.nfields < msp_pkg::FCNT_SAT) begin
				s.nfields = s.nfields + 1'b1;
			end
		end
		if (s.nfields == msp_pkg::FCNT_PAN) begin
			if (ascii_digit(c)) begin
				if (s.pan_cnt < msp_pkg::PAN_MAX_DEF) begin
					s.pan[s.pan_cnt] = c[3:0];
					s.pan_cnt = s.pan_cnt + 1'b1;
				end else begin
					s.pan_ovf = 1'b1;
				end
			end
		end else if (s.nfields == date_field) begin
			if (s.date_cnt < msp_pkg::EXP_CHARS) begin
				s.date[s.date_cnt] = c;
				s.date_cnt = s.date_cnt + 1'b1;
			end
		end
		return s;
	endfunction

	function automatic track_result_t take_track(field_split_t s, logic [1:0] src);
		track_result_t r;
		r = '0;
		for (int i = 0; i < s.pan_cnt; i++) begin
			if (i < msp_pkg::LOW_DIGITS) begin
				r.pan_lo[4*i +: 4] = s.pan[i];
			end else begin
				r.pan_hi[4*(i-msp_pkg::LOW_DIGITS) +: 4] = s.pan[i];
			end
		end
		r.pan_len = s.pan_cnt;
		r.pan_ovf = s.pan_ovf;
		r.src     = src;
		if (s.date_cnt >= msp_pkg::EXP_CHARS) begin
			r.exp_valid = 1'b1;
			r.year      = msp_pkg::YEAR_BASE + 12'(yymm_value(s.date[0], s.date[1]));
			r.month     = 7'(yymm_value(s.date[2], s.date[3]));
		end
		return r;
	endfunction

	task automatic clear_parser();
		seg_count    = 2'd0;
		seg_open     = 1'b0;
		caret_found  = 1'b0;
		track1_split = '0;
		track2_split = '0;
	endtask

	task automatic predict_char(logic [7:0] c, logic last);
		track_result_t r;
		logic          t1_fields;
		logic          t1_valid;
		logic          t2_present;
		if (c == msp_pkg::CH_SEMI) begin
			seg_open = 1'b0;
		end else begin
			if (!seg_open) begin
				seg_open = 1'b1;
				if (seg_count < msp_pkg::SEG_MAX) begin
					seg_count = seg_count + 1'b1;
				end
				if (seg_count == msp_pkg::SEG_SECOND) begin
					track2_split = '0;
				end
			end
			// The first segment feeds both splitters, whatever its kind.
			if (seg_count == msp_pkg::SEG_FIRST) begin
				if (c == msp_pkg::CH_CARET) begin
					caret_found = 1'b1;
				end
				track1_split = split_step(track1_split, c, msp_pkg::CH_CARET,
					msp_pkg::FCNT_T1_DATE);
				track2_split = split_step(track2_split, c, msp_pkg::CH_EQUAL,
					msp_pkg::FCNT_T2_DATE);
			end else if (seg_count == msp_pkg::SEG_SECOND) begin
				track2_split = split_step(track2_split, c, msp_pkg::CH_EQUAL,
					msp_pkg::FCNT_T2_DATE);
			end
		end
		if (last) begin
			r = '0;
			t1_fields  = caret_found && track1_split.nfields >= msp_pkg::FCNT_T1_DATE;
			t1_valid   = t1_fields && track1_split.date_cnt >= msp_pkg::EXP_CHARS;
			t2_present = seg_count >= msp_pkg::SEG_SECOND
				|| (seg_count == msp_pkg::SEG_FIRST && !caret_found);
			if (t1_fields) begin
				r = take_track(track1_split, msp_pkg::SRC_TRACK1);
			end
			if (!t1_valid && t2_present && track2_split.nfields >= msp_pkg::FCNT_T2_DATE) begin
				r = take_track(track2_split, msp_pkg::SRC_TRACK2);
			end
			expected_results.push_back(r);
			clear_parser();
		end
	endtask

	// Text building for the stimulus.
	task automatic commit_text();
		track_char_t item;
		if (track_text.size() == 0) begin
			track_text.push_back(msp_pkg::CH_SEMI);
		end
		for (int i = 0; i < track_text.size(); i++) begin
			item.code = track_text[i];
			item.last = (i == track_text.size() - 1);
			pending_chars.push_back(item);
		end
		track_text.delete();
	endtask

	task automatic commit_string(string s);
		for (int i = 0; i < s.len(); i++) begin
			track_text.push_back(s[i]);
		end
		commit_text();
	endtask

	task automatic add_digits(int n);
		for (int i = 0; i < n; i++) begin
			track_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic add_name(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				track_text.push_back($urandom_range(0, 1) ? 8'h20 : 8'h2F);
			end else begin
				track_text.push_back(8'h41 + 8'($urandom_range(0, 25)));
			end
		end
	endtask

	task automatic add_noise(int n);
		for (int i = 0; i < n; i++) begin
			track_text.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Mostly four or more date chars, now and then a letter among them.
	task automatic add_date();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(4, 7);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				track_text.push_back(8'h41 + 8'($urandom_range(0, 25)));
			end else begin
				track_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
			end
		end
	endtask

	function automatic int pan_size();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(15, 23) : $urandom_range(0, 10);
	endfunction

	task automatic add_track1();
		if ($urandom_range(0, 1)) track_text.push_back(8'h25);
		if ($urandom_range(0, 1)) track_text.push_back(8'h42);
		add_digits(pan_size());
		track_text.push_back(msp_pkg::CH_CARET);
		if ($urandom_range(0, 4) == 0) track_text.push_back(msp_pkg::CH_CARET);
		add_name($urandom_range(0, 12));
		track_text.push_back(msp_pkg::CH_CARET);
		if ($urandom_range(0, 4) == 0) track_text.push_back(msp_pkg::CH_CARET);
		add_date();
		add_digits($urandom_range(0, 6));
		if ($urandom_range(0, 5) == 0) begin
			track_text.push_back(msp_pkg::CH_CARET);
			add_digits($urandom_range(0, 3));
		end
	endtask

	task automatic add_track2();
		add_digits(pan_size());
		track_text.push_back(msp_pkg::CH_EQUAL);
		if ($urandom_range(0, 4) == 0) track_text.push_back(msp_pkg::CH_EQUAL);
		add_date();
		add_digits($urandom_range(0, 6));
		if ($urandom_range(0, 7) == 0) begin
			track_text.push_back(msp_pkg::CH_EQUAL);
			add_date();
		end
	endtask

	task automatic add_mixed(int n);
		logic [7:0] pick;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: pick = msp_pkg::CH_SEMI;
				1: pick = msp_pkg::CH_CARET;
				2: pick = msp_pkg::CH_EQUAL;
				3: pick = 8'h41;
				default: pick = 8'h30 + 8'($urandom_range(0, 9));
			endcase
			track_text.push_back(pick);
		end
	endtask

	task automatic queue_random_text();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				if ($urandom_range(0, 1)) track_text.push_back(msp_pkg::CH_SEMI);
				add_track1();
				track_text.push_back(msp_pkg::CH_SEMI);
				if ($urandom_range(0, 3) == 0) track_text.push_back(msp_pkg::CH_SEMI);
				add_track2();
			end
			4, 5: begin
				if ($urandom_range(0, 1)) track_text.push_back(msp_pkg::CH_SEMI);
				add_track2();
			end
			6: add_track1();
			7: begin
				if ($urandom_range(0, 1)) add_track1(); else add_track2();
				track_text.push_back(msp_pkg::CH_SEMI);
				add_track2();
				track_text.push_back(msp_pkg::CH_SEMI);
				if ($urandom_range(0, 1)) add_track2(); else add_noise($urandom_range(1, 6));
			end
			8: add_noise($urandom_range(1, 12));
			default: add_mixed($urandom_range(1, 16));
		endcase
		if ($urandom_range(0, 3) == 0) track_text.push_back(8'h3F);
		commit_text();
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: bursts of random length with random gaps between them.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			char_code  <= 8'h00;
			last_char  <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_char(pending_chars[0].code, pending_chars[0].last);
				void'(pending_chars.pop_front());
			end
			// A stalled item stays on the bus unchanged.
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_chars.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					in_valid  <= 1'b1;
					char_code <= pending_chars[0].code;
					last_char <= pending_chars[0].last;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Receiver: stall pattern is redrawn at random, plus one long
	// hold-off so that the block fills up and stalls its input.
	int rx_cycle;
	int hold_left;
	int stall_mode;
	int mode_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			rx_cycle   = 0;
			hold_left  = 0;
			stall_mode = 0;
			mode_left  = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 80);
				end
				mode_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= $urandom_range(0, 1);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		track_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no pending track text");
				errors++;
			end else begin
				want = expected_results.pop_front();
				compare_field("pan_digits_low", want.pan_lo, pan_digits_low);
				compare_field("pan_digits_high", 64'(want.pan_hi), 64'(pan_digits_high));
				compare_field("pan_length", 64'(want.pan_len), 64'(pan_length));
				compare_field("pan_overflow", 64'(want.pan_ovf), 64'(pan_overflow));
				compare_field("source_track", 64'(want.src), 64'(source_track));
				compare_field("expiry_valid", 64'(want.exp_valid), 64'(expiry_valid));
				compare_field("expiry_year", 64'(want.year), 64'(expiry_year));
				compare_field("expiry_month", 64'(want.month), 64'(expiry_month));
			end
		end
	end

	// Watchdog on cycles where neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("magstripe_track_parser_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		clear_parser();

		// Directed texts: empty input, odd bytes, valid and short track 1,
		// track 2 taking over, long account, ignored third segment,
		// letters in the date, separators only.
		commit_string(";");
		track_text.push_back(8'hFF);
		commit_text();
		track_text.push_back(8'h00);
		commit_text();
		commit_string("B41^A^2512");
		commit_string("1^A^25;9=2612");
		commit_string("1^A^25");
		commit_string("12345678901234567890^^A^^9912");
		commit_string("5=A9B1;;7=0101;3=99");
		commit_string("5==X9Y1");
		commit_string(";;^^;");
		commit_string("4=1299");
		commit_string("9^Z^0000");

		while (pending_chars.size() < RANDOM_CHARS) begin
			queue_random_text();
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() != 0 || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("magstripe_track_parser_tb: clean");
		end else begin
			$display("magstripe_track_parser_tb: errors");
		end
		$finish;
	end

endmodule
